// File: src/scb_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text cell buffer package
// Shared constants and types for the character cell buffer and its checker.
// ----------------------------------------------------------------------------
package scb_pkg;

   // Default geometry of the display and of the ring store.
   localparam int COLUMNS_DEFAULT    = 14;
   localparam int ROWS_DEFAULT       = 6;
   localparam int RING_DEPTH_DEFAULT = 128;

   // Widths of the item fields.
   localparam int OPCODE_W = 1;
   localparam int CODE_W   = 8;
   localparam int INDEX_W  = 7;
   localparam int GLYPH_W  = 7;
   localparam int CURSOR_W = 7;

   // Largest glyph index that a read can return.
   localparam logic [GLYPH_W-1:0] GLYPH_MAX = GLYPH_W'(95);

   // Character codes with a meaning of their own.
   localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;
   localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } opcode_type;

endpackage

// File: src/scb_ring_adder.sv
// ----------------------------------------------------------------------------
// Ring address unit
// Adds an offset to a base address and wraps the sum into the ring store.
// ----------------------------------------------------------------------------
module scb_ring_adder
   import scb_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic [$clog2(RING_DEPTH)-1:0] base,
   input  logic [$clog2(RING_DEPTH)-1:0] offset,
   output logic [$clog2(RING_DEPTH)-1:0] addr
);

   localparam int                AW      = $clog2(RING_DEPTH);
   localparam logic [AW:0]       DEPTH_C = (AW+1)'(RING_DEPTH);

   logic [AW:0] sum;

   // Both operands stay below the depth, so one conditional subtract wraps.
   always_comb begin
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_C) begin
         sum = sum - DEPTH_C;
      end
      addr = sum[AW-1:0];
   end

endmodule

// File: src/scb_cell_ram.sv
// ----------------------------------------------------------------------------
// Cell store
// Single-port character memory with a registered read.
// ----------------------------------------------------------------------------
module scb_cell_ram
   import scb_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0] addr,
   input  logic [CODE_W-1:0]             wr_data,
   output logic [CODE_W-1:0]             rd_data_ff
);

   logic [CODE_W-1:0] mem [RING_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

endmodule

// File: src/scb_sequencer.sv
// ----------------------------------------------------------------------------
// Buffer sequencer
// Walks each item through its steps, drives the ring address unit and the
// cell store, keeps the cursor and ring head and holds the result register.
// ----------------------------------------------------------------------------
module scb_sequencer
   import scb_pkg::*;
#(
   parameter int COLUMNS    = COLUMNS_DEFAULT,
   parameter int ROWS       = ROWS_DEFAULT,
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [OPCODE_W-1:0]           req_opcode,
   input  logic [CODE_W-1:0]             req_char_code,
   input  logic [INDEX_W-1:0]            req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [GLYPH_W-1:0]            rsp_glyph_index,
   output logic [CURSOR_W-1:0]           rsp_cursor_pos,
   output logic [$clog2(RING_DEPTH)-1:0] unit_base,
   output logic [$clog2(RING_DEPTH)-1:0] unit_offset,
   input  logic [$clog2(RING_DEPTH)-1:0] unit_addr,
   output logic                          ram_wr_en,
   output logic [CODE_W-1:0]             ram_wr_data,
   input  logic [CODE_W-1:0]             ram_rd_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int AW     = $clog2(RING_DEPTH);
   localparam int CUR_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CMP_W  = CUR_W + INDEX_W;

   localparam logic [CUR_W-1:0] CELLS_C     = CUR_W'(CELLS);
   localparam logic [CUR_W-1:0] LAST_ROW_C  = CUR_W'(CELLS - COLUMNS);
   localparam logic [CUR_W-1:0] COLUMNS_CUR = CUR_W'(COLUMNS);
   localparam logic [COL_W-1:0] LAST_COL_C  = COL_W'(COLUMNS - 1);
   localparam logic [AW-1:0]    COLUMNS_A   = AW'(COLUMNS);
   localparam logic [AW-1:0]    LAST_ROW_A  = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0]    LAST_CELL_A = AW'(CELLS - 1);
   localparam logic [AW-1:0]    LAST_ADDR_A = AW'(RING_DEPTH - 1);
   localparam logic [CMP_W-1:0] CELLS_CMP   = CMP_W'(CELLS);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_FETCH  = 8'b0000_1000,
      S_WRITE  = 8'b0001_0000,
      S_SCROLL = 8'b0010_0000,
      S_STORE  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [CUR_W-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        fill_ff, fill_in;
   logic [GLYPH_W-1:0]   glyph_ff, glyph_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_W-1:0]   rsp_glyph_ff, rsp_glyph_in;
   logic [CURSOR_W-1:0]  rsp_cursor_ff, rsp_cursor_in;

   logic                 out_free;
   logic                 idx_in_range;
   logic [CMP_W-1:0]     cursor_wide;

   // Codes below the space and above 127 have no glyph.
   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] diff;
      diff = code - CODE_SPACE;
      if (code[CODE_W-1] || (code < CODE_SPACE)) begin
         return '0;
      end
      return diff[GLYPH_W-1:0];
   endfunction

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign idx_in_range = CMP_W'(req_cell_index) < CELLS_CMP;
   assign cursor_wide  = CMP_W'(cursor_ff);

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glyph_index = rsp_glyph_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;

   // Operands of the ring address unit and the store's write port.
   always_comb begin
      unit_base   = head_ff;
      unit_offset = '0;
      ram_wr_en   = 1'b0;
      ram_wr_data = code_ff;
      unique case (state_ff)
         S_CLEAR: begin
            unit_base   = '0;
            unit_offset = fill_ff;
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
         end
         S_READ: begin
            unit_offset = AW'(idx_ff);
         end
         S_WRITE: begin
            unit_offset = COLUMNS_A;
         end
         S_SCROLL: begin
            unit_offset = fill_ff;
            ram_wr_en   = 1'b1;
            ram_wr_data = CODE_SPACE;
         end
         S_STORE: begin
            unit_offset = AW'(cursor_ff);
            ram_wr_en   = 1'b1;
         end
         default: begin
            unit_offset = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      glyph_in      = glyph_ff;
      rsp_glyph_in  = rsp_glyph_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_CLEAR: begin
            fill_in = fill_ff + AW'(1);
            if (fill_ff == LAST_ADDR_A) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               code_in  = req_char_code;
               idx_in   = req_cell_index;
               glyph_in = '0;
               if (opcode_type'(req_opcode) == OP_WRITE) begin
                  state_in = S_WRITE;
               end else if (idx_in_range) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            glyph_in = glyph_of(ram_rd_data);
            state_in = S_DONE;
         end
         S_WRITE: begin
            if (code_ff == CODE_NEWLINE) begin
               if (cursor_ff > LAST_ROW_C) begin
                  cursor_in = CELLS_C;
               end else if (col_ff != '0) begin
                  cursor_in = cursor_ff - CUR_W'(col_ff) + COLUMNS_CUR;
               end
               col_in   = '0;
               state_in = S_DONE;
            end else if (code_ff == CODE_RETURN) begin
               cursor_in = cursor_ff - CUR_W'(col_ff);
               col_in    = '0;
               state_in  = S_DONE;
            end else if (cursor_ff == CELLS_C) begin
               cursor_in = LAST_ROW_C;
               col_in    = '0;
               head_in   = unit_addr;
               fill_in   = LAST_ROW_A;
               state_in  = S_SCROLL;
            end else begin
               state_in = S_STORE;
            end
         end
         S_SCROLL: begin
            fill_in = fill_ff + AW'(1);
            if (fill_ff == LAST_CELL_A) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cursor_in = cursor_ff + CUR_W'(1);
            col_in    = (col_ff == LAST_COL_C) ? '0 : col_ff + COL_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_glyph_in  = glyph_ff;
               rsp_cursor_in = cursor_wide[CURSOR_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cursor_ff    <= '0;
         col_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      code_ff       <= code_in;
      idx_ff        <= idx_in;
      glyph_ff      <= glyph_in;
      rsp_glyph_ff  <= rsp_glyph_in;
      rsp_cursor_ff <= rsp_cursor_in;
   end

endmodule

// File: src/scrolling_text_cell_buffer.sv
// ----------------------------------------------------------------------------
// Scrolling text cell buffer
// Character cell store with a cursor and a scrolling ring for a small display.
// ----------------------------------------------------------------------------
// The buffer holds COLUMNS x ROWS character cells (14 x 6 by default) in a
// ring store of RING_DEPTH bytes; ROWS x COLUMNS must not exceed RING_DEPTH.
// After reset the store is swept to zero one entry per cycle, and req_stall
// stays high until the sweep ends. Each item is then worked on alone and
// req_stall is high until its result has been placed in the output register;
// the next item may be taken while that result still waits on rsp_stall. A
// read passes through the READ, FETCH and DONE states, an out-of-range read
// only DONE, a newline or carriage return WRITE and DONE, a stored character
// WRITE, STORE and DONE, and a character written while the cursor is parked
// WRITE, SCROLL, STORE and DONE, because the new bottom row is filled with
// spaces one cell per cycle through the store's single write port. Every
// store access goes through one shared ring address unit that adds a logical
// offset to a base (the ring head outside the clearing sweep) and wraps it.
// ----------------------------------------------------------------------------
module scrolling_text_cell_buffer
   import scb_pkg::*;
#(
   parameter int COLUMNS    = COLUMNS_DEFAULT,
   parameter int ROWS       = ROWS_DEFAULT,
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [GLYPH_W-1:0]  rsp_glyph_index,
   output logic [CURSOR_W-1:0] rsp_cursor_pos
);

   localparam int AW = $clog2(RING_DEPTH);

   // Operands and result of the shared ring address unit.
   logic [AW-1:0]     unit_base;
   logic [AW-1:0]     unit_offset;
   logic [AW-1:0]     unit_addr;

   // Cell store port.
   logic              ram_wr_en;
   logic [CODE_W-1:0] ram_wr_data;
   logic [CODE_W-1:0] ram_rd_data;

   // The sequencer owns the cursor, the ring head, the clearing sweep and
   // the result register.
   scb_sequencer #(
      .COLUMNS    (COLUMNS),
      .ROWS       (ROWS),
      .RING_DEPTH (RING_DEPTH)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_char_code   (req_char_code),
      .req_cell_index  (req_cell_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .unit_base       (unit_base),
      .unit_offset     (unit_offset),
      .unit_addr       (unit_addr),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_data     (ram_rd_data)
   );

   // Logical cell to physical store address.
   scb_ring_adder #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring_adder (
      .base   (unit_base),
      .offset (unit_offset),
      .addr   (unit_addr)
   );

   // Character store; the read data is registered, so it appears in the cycle after the address.
   scb_cell_ram #(
      .RING_DEPTH (RING_DEPTH)
   ) u_cell_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .addr       (unit_addr),
      .wr_data    (ram_wr_data),
      .rd_data_ff (ram_rd_data)
   );

endmodule

// File: src/scb_checker.sv
// ----------------------------------------------------------------------------
// Scrolling text cell buffer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module scb_checker
   import scb_pkg::*;
#(
   parameter int COLUMNS    = COLUMNS_DEFAULT,
   parameter int ROWS       = ROWS_DEFAULT,
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [GLYPH_W-1:0]  rsp_glyph_index,
   input logic [CURSOR_W-1:0] rsp_cursor_pos
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam logic [CURSOR_W:0] CELLS_C = (CURSOR_W+1)'(CELLS);

   // No result is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // One item at a time: an accepted item holds off the next one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in work");

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_glyph_index) && $stable(rsp_cursor_pos)))
      else $error("stalled result changed");

   // Glyphs stay within the font.
   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_glyph_index <= GLYPH_MAX))
      else $error("glyph index beyond font");

   // The cursor never passes the parked position.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((CELLS > 127) || ({1'b0, rsp_cursor_pos} <= CELLS_C)))
      else $error("cursor beyond parked position");

endmodule

bind scrolling_text_cell_buffer scb_checker #(
   .COLUMNS    (COLUMNS),
   .ROWS       (ROWS),
   .RING_DEPTH (RING_DEPTH)
) u_scb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_glyph_index (rsp_glyph_index),
   .rsp_cursor_pos  (rsp_cursor_pos)
);

// File: dv/scb_checker_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text cell buffer checker
// Predicts glyph and cursor for each accepted item and checks the results.
// ----------------------------------------------------------------------------
package scb_checker_pkg;
   import scb_pkg::*;

   localparam int CELLS          = ROWS_DEFAULT * COLUMNS_DEFAULT;
   localparam int LAST_ROW_START = CELLS - COLUMNS_DEFAULT;

   typedef struct packed {
      logic [GLYPH_W-1:0]  glyph;
      logic [CURSOR_W-1:0] cursor;
   } glyph_cursor_type;

   class cell_buffer_scoreboard;
      logic [CODE_W-1:0] ring_cells [RING_DEPTH_DEFAULT];
      int unsigned       ring_head;
      int unsigned       cursor;
      glyph_cursor_type  due_glyph_cursor [$];
      int                errors;
      int                compared;
      int                writes;
      int                reads;
      int                scrolls;
      int                newlines;
      int                returns;
      int                far_reads;

      function new();
         foreach (ring_cells[i]) ring_cells[i] = '0;
         ring_head = 0;
         cursor    = 0;
      endfunction

      function int unsigned ring_slot(int unsigned logical);
         return (ring_head + logical) % RING_DEPTH_DEFAULT;
      endfunction

      // Applies one accepted item to the shadow state and queues its result.
      function void note_request(opcode_type op, logic [CODE_W-1:0] code,
                                 logic [INDEX_W-1:0] idx);
         glyph_cursor_type  due;
         int unsigned       col;
         logic [CODE_W-1:0] stored;
         due.glyph = '0;
         if (op == OP_WRITE) begin
            writes++;
            col = cursor % COLUMNS_DEFAULT;
            if (code == CODE_NEWLINE) begin
               newlines++;
               if (cursor > LAST_ROW_START)
                  cursor = CELLS;
               else if (col != 0)
                  cursor += COLUMNS_DEFAULT - col;
            end else if (code == CODE_RETURN) begin
               returns++;
               cursor -= col;
            end else begin
               if (cursor >= CELLS) begin
                  // Parked: scroll one row and blank the new bottom row first.
                  scrolls++;
                  cursor    = LAST_ROW_START;
                  ring_head = (ring_head + COLUMNS_DEFAULT) % RING_DEPTH_DEFAULT;
                  for (int k = 0; k < COLUMNS_DEFAULT; k++)
                     ring_cells[ring_slot(cursor + k)] = CODE_SPACE;
               end
               ring_cells[ring_slot(cursor)] = code;
               cursor++;
            end
         end else begin
            reads++;
            if (idx >= CELLS) begin
               far_reads++;
            end else begin
               stored = ring_cells[ring_slot(idx)];
               if (stored >= CODE_SPACE && stored <= 8'd127)
                  due.glyph = GLYPH_W'(stored - CODE_SPACE);
            end
         end
         due.cursor = CURSOR_W'(cursor);
         due_glyph_cursor.push_back(due);
      endfunction

      function void check_result(logic [GLYPH_W-1:0] glyph,
                                 logic [CURSOR_W-1:0] pos);
         glyph_cursor_type due;
         if (due_glyph_cursor.size() == 0) begin
            $display("%0t: result with nothing outstanding, glyph_index %0d cursor_pos %0d",
                     $time, glyph, pos);
            errors++;
            return;
         end
         due = due_glyph_cursor.pop_front();
         compared++;
         if (glyph !== due.glyph) begin
            $display("%0t: glyph_index mismatch, expected %0d, actual %0d",
                     $time, due.glyph, glyph);
            errors++;
         end
         if (pos !== due.cursor) begin
            $display("%0t: cursor_pos mismatch, expected %0d, actual %0d",
                     $time, due.cursor, pos);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_glyph_cursor.size();
      endfunction
   endclass

endpackage

// File: dv/scrolling_text_cell_buffer_tb.sv
// ----------------------------------------------------------------------------
// Scrolling text cell buffer testbench
// Drives character writes and cell reads through the request channel, checks
// every result against a cycle-free shadow of the buffer, and exercises
// parking, scrolling and ring wrap under random sender and receiver idling.
// ----------------------------------------------------------------------------
module scrolling_text_cell_buffer_tb
   import scb_pkg::*;
   import scb_checker_pkg::*;
();

   // Number of random items after the directed opening.
   localparam int RANDOM_ITEMS = 1025;
   // The receiver holds off once this many items have been taken.
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   // Cycles with no item moving on either channel before the run is declared
   // hung. The clearing sweep after reset and the long hold-off both fit
   // well inside it.
   localparam int IDLE_LIMIT   = 2000;
   // Cycles allowed after the last result.
   localparam int DRAIN_CYCLES = 40;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode;
   logic [CODE_W-1:0]   req_char_code;
   logic [INDEX_W-1:0]  req_cell_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [GLYPH_W-1:0]  rsp_glyph_index;
   logic [CURSOR_W-1:0] rsp_cursor_pos;

   cell_buffer_scoreboard board;
   int items_taken;
   int burst_left;
   bit held_off;

   scrolling_text_cell_buffer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_char_code   (req_char_code),
      .req_cell_index  (req_cell_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_glyph_index (rsp_glyph_index),
      .rsp_cursor_pos  (rsp_cursor_pos)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Everything is driven at the rising edge, so values seen at the falling
   // edge are exactly the ones the next rising edge will act upon. Both
   // channels are therefore sampled there, which keeps the checks free of any
   // dependence on event order within a time step.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_glyph_index, rsp_cursor_pos);
   end

   // Offers one item and holds it until the block takes it. The sender works
   // in bursts: when a burst runs out, valid may drop for a random gap, but a
   // gap of zero keeps valid high straight into the next item.
   task automatic offer_item(input opcode_type op, input logic [CODE_W-1:0] code,
                             input logic [INDEX_W-1:0] idx);
      bit took;
      int gap;
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_char_code  <= code;
      req_cell_index <= idx;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      board.note_request(op, code, idx);
      items_taken++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            // The payload is scrambled while valid is low; it must be ignored.
            req_valid      <= 1'b0;
            req_opcode     <= OPCODE_W'($urandom_range(0, 1));
            req_char_code  <= CODE_W'($urandom);
            req_cell_index <= INDEX_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_char(input logic [CODE_W-1:0] code);
      offer_item(OP_WRITE, code, INDEX_W'($urandom));
   endtask

   task automatic read_cell(input logic [INDEX_W-1:0] idx);
      offer_item(OP_READ, CODE_W'($urandom), idx);
   endtask

   // The receiver stalls in segments of random length, each with a mood of
   // its own: never, half the time, mostly, or every other cycle. Once, after
   // enough items have gone in, it refuses results for a long stretch so that
   // the output register and the block behind it fill and stall the sender.
   initial begin
      int seg;
      int mood;
      rsp_stall <= 1'b0;
      forever begin
         mood = $urandom_range(0, 3);
         seg  = $urandom_range(4, 40);
         for (int k = 0; k < seg; k++) begin
            @(posedge clock);
            if (!held_off && items_taken >= HOLD_AT) begin
               held_off = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES - 1) @(posedge clock);
            end else begin
               case (mood)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 4) != 0);
                  default: rsp_stall <= k[0];
               endcase
            end
         end
      end
   end

   // Hang detector: counts cycles in which neither channel moves an item.
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no item moved for %0d cycles, %0d results still due",
               $time, IDLE_LIMIT, board.outstanding());
      $display("status: fail");
      $finish;
   end

   initial begin
      int pick;
      int failures;
      board          = new();
      items_taken    = 0;
      burst_left     = 0;
      held_off       = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OP_WRITE;
      req_char_code  <= '0;
      req_cell_index <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. Reads beyond the display first, at the top of the
      // index range and just past the last cell.
      read_cell(7'd127);
      read_cell(7'd84);
      // The extremes of the code byte, a control code and both edges of
      // the printable range all go into row 0.
      write_char(8'd0);
      write_char(8'd255);
      write_char(8'd127);
      write_char(8'd31);
      write_char(CODE_SPACE);
      // Newline part way along a row, then a character and a carriage return.
      write_char(CODE_NEWLINE);
      write_char(8'd72);
      write_char(CODE_RETURN);
      read_cell(7'd2);
      read_cell(7'd1);
      read_cell(7'd14);
      // Walk down to the last row one line at a time.
      for (int r = 0; r < ROWS_DEFAULT - 2; r++) begin
         write_char(CODE_SPACE + 8'd33 + CODE_W'(r));
         write_char(CODE_NEWLINE);
      end
      // Newline at the start of the last row stays put; past it, it parks.
      write_char(CODE_NEWLINE);
      write_char(8'd69);
      write_char(CODE_NEWLINE);
      // Carriage return and newline while parked both leave the cursor there.
      write_char(CODE_RETURN);
      write_char(CODE_NEWLINE);
      // A character while parked scrolls the display by one row.
      write_char(8'd70);
      read_cell(7'd70);
      read_cell(7'd0);

      // Random part: mostly printable text with line breaks and reads, which
      // keeps the cursor marching down to the parked position and scrolling
      // the ring many times round; the rest is arbitrary bytes and reads
      // beyond the display.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            write_char(CODE_W'($urandom_range(32, 126)));
         else if (pick < 48)
            write_char(CODE_NEWLINE);
         else if (pick < 52)
            write_char(CODE_RETURN);
         else if (pick < 58)
            write_char(CODE_W'($urandom_range(0, 255)));
         else if (pick < 95)
            read_cell(INDEX_W'($urandom_range(0, CELLS - 1)));
         else
            read_cell(INDEX_W'($urandom_range(CELLS, 127)));
      end
      req_valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      failures = board.errors + board.outstanding();
      $display("Covered %0d writes (%0d newlines, %0d returns, %0d scrolls) and %0d reads",
               board.writes, board.newlines, board.returns, board.scrolls, board.reads);
      $display("(%0d beyond the display); %0d results compared, long hold-off %s.",
               board.far_reads, board.compared, held_off ? "done" : "missed");
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
src/scb_pkg.sv
src/scb_ring_adder.sv
src/scb_cell_ram.sv
src/scb_sequencer.sv
src/scrolling_text_cell_buffer.sv
src/scb_checker.sv
dv/scb_checker_pkg.sv
dv/scrolling_text_cell_buffer_tb.sv
